/* src/nca_pkg.sv */
`default_nettype none

package nca_pkg;

  // Opcodes of the input channel
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_POINT = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // Field and datapath widths
  localparam int OPC_W  = 2;
  localparam int CIDX_W = 4;
  localparam int DIM_W  = 4;
  localparam int VAL_W  = 16;
  localparam int CLU_W  = 4;
  localparam int CFG_W  = 5;
  localparam int CNT_W  = 7;   // holds a centroid count up to 64
  localparam int IDX_W  = 6;   // holds a centroid index up to 63
  localparam int SQ_W   = 32;  // square of a 16-bit magnitude
  localparam int PART_W = 37;
  localparam int DIST_W = 36;
  localparam int COST_W = 56;

  localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

  // One item as it travels down the row of cells
  typedef struct packed {
    logic               valid;
    logic [OPC_W-1:0]   op;
    logic [CIDX_W-1:0]  cidx;
    logic [DIM_W-1:0]   didx;
    logic               dim_ok;
    logic signed [VAL_W-1:0] value;
    logic               last;
    logic [CNT_W-1:0]   n_act;
  } item_t;

  // Running nearest-centroid search, handed from cell to cell
  typedef struct packed {
    logic              valid;
    logic              res;
    logic              clear;
    logic              have;
    logic [PART_W-1:0] best_d;
    logic [IDX_W-1:0]  best_idx;
  } tok_t;

endpackage

`default_nettype wire

/* src/nca_in_if.sv */
`default_nettype none

interface nca_in_if;
  logic                              valid;
  logic                              ready;
  logic [nca_pkg::OPC_W-1:0]         opcode;
  logic [nca_pkg::CIDX_W-1:0]        centroid_index;
  logic [nca_pkg::DIM_W-1:0]         dim_index;
  logic signed [nca_pkg::VAL_W-1:0]  value;
  logic                              last_coord;

  modport source (output valid, opcode, centroid_index, dim_index, value, last_coord,
                  input ready);
  modport sink (input valid, opcode, centroid_index, dim_index, value, last_coord,
                output ready);
endinterface

`default_nettype wire

/* src/nca_out_if.sv */
`default_nettype none

interface nca_out_if;
  logic                        valid;
  logic                        ready;
  logic [nca_pkg::CLU_W-1:0]   cluster;
  logic [nca_pkg::DIST_W-1:0]  min_distance_sq;
  logic [nca_pkg::COST_W-1:0]  cost_total;

  modport source (output valid, cluster, min_distance_sq, cost_total, input ready);
  modport sink (input valid, cluster, min_distance_sq, cost_total, output ready);
endinterface

`default_nettype wire

/* src/nca_cell.sv */
`default_nettype none

// One centroid: its coordinate store, squared-difference unit, partial
// distance and one step of the nearest search.
module nca_cell #(
  parameter int CELL_IDX = 0,
  parameter int MAX_DIMS = 16
) (
  input  wire                   clk,
  input  wire                   rst_n,
  input  wire                   adv,
  input  wire                   clr_en,
  input  wire [((MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1)-1:0] clr_addr,
  input  nca_pkg::item_t        item_i,
  output nca_pkg::item_t        item_o,
  input  nca_pkg::tok_t         tok_i,
  output nca_pkg::tok_t         tok_o
);

  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
  localparam int XW = (DW > nca_pkg::DIM_W) ? DW : nca_pkg::DIM_W;

  logic [nca_pkg::VAL_W-1:0]  mem_r [MAX_DIMS];
  logic [nca_pkg::VAL_W-1:0]  rd_r;
  nca_pkg::item_t             b_r;
  nca_pkg::item_t             c_r;
  nca_pkg::tok_t              tok_r;
  nca_pkg::tok_t              tok_nxt;
  logic [nca_pkg::SQ_W-1:0]   sq_r;
  logic [nca_pkg::SQ_W-1:0]   sq_nxt;
  logic [nca_pkg::PART_W-1:0] partial_r;
  logic [nca_pkg::PART_W-1:0] partial_nxt;

  logic [XW-1:0] dim_x;
  logic [DW-1:0] addr;
  logic          ld_hit;

  // Stage A: table write for loads, registered read for points
  assign dim_x  = XW'(item_i.didx);
  assign addr   = dim_x[DW-1:0];
  assign ld_hit = item_i.valid && (item_i.op == nca_pkg::OP_LOAD) && item_i.dim_ok &&
                  (nca_pkg::CNT_W'(item_i.cidx) == nca_pkg::CNT_W'(CELL_IDX));

  always_ff @(posedge clk) begin
    if (clr_en) begin
      mem_r[clr_addr] <= '0;
    end else if (adv && ld_hit) begin
      mem_r[addr] <= item_i.value;
    end
    if (adv) begin
      rd_r <= mem_r[addr];
    end
  end

  // Stage B: squared difference, zero when this cell takes no part
  logic signed [nca_pkg::VAL_W:0] diff;
  logic [nca_pkg::VAL_W:0]        mag17;
  logic [nca_pkg::VAL_W-1:0]      mag;
  logic                           acc_b;

  always_comb begin
    diff  = $signed({b_r.value[nca_pkg::VAL_W-1], b_r.value}) -
            $signed({rd_r[nca_pkg::VAL_W-1], rd_r});
    mag17 = diff[nca_pkg::VAL_W] ? (17'd0 - 17'(diff)) : 17'(diff);
    mag   = mag17[nca_pkg::VAL_W-1:0];
    acc_b = b_r.valid && (b_r.op == nca_pkg::OP_POINT) && b_r.dim_ok &&
            (b_r.n_act > nca_pkg::CNT_W'(CELL_IDX));
    sq_nxt = acc_b ? (mag * mag) : '0;
  end

  // Stage C: saturating accumulate, then compare against the incoming best
  logic [nca_pkg::PART_W:0]   sum;
  logic [nca_pkg::PART_W-1:0] sat;
  logic                       active_c;
  logic                       take;

  always_comb begin
    sum      = {1'b0, partial_r} + (nca_pkg::PART_W + 1)'(sq_r);
    sat      = sum[nca_pkg::PART_W] ? '1 : sum[nca_pkg::PART_W-1:0];
    active_c = c_r.n_act > nca_pkg::CNT_W'(CELL_IDX);
    take     = active_c && (!tok_i.have || (sat < tok_i.best_d));

    partial_nxt = partial_r;
    if (c_r.valid && (c_r.op == nca_pkg::OP_POINT)) begin
      partial_nxt = c_r.last ? '0 : sat;
    end

    tok_nxt.valid    = c_r.valid;
    tok_nxt.res      = c_r.valid && (c_r.op == nca_pkg::OP_POINT) && c_r.last;
    tok_nxt.clear    = c_r.valid && (c_r.op == nca_pkg::OP_CLEAR);
    tok_nxt.have     = tok_i.have || active_c;
    tok_nxt.best_d   = take ? sat : tok_i.best_d;
    tok_nxt.best_idx = take ? nca_pkg::IDX_W'(CELL_IDX) : tok_i.best_idx;
  end

  // Pipeline registers, all frozen while the output stalls
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_r       <= '0;
      c_r       <= '0;
      tok_r     <= '0;
      partial_r <= '0;
    end else if (adv) begin
      b_r       <= item_i;
      c_r       <= b_r;
      tok_r     <= tok_nxt;
      partial_r <= partial_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sq_r <= sq_nxt;
    end
  end

  assign item_o = b_r;
  assign tok_o  = tok_r;

endmodule

`default_nettype wire

/* src/nca_cost.sv */
`default_nettype none

// End of the row: cost accumulator and output register.
module nca_cost (
  input  wire              clk,
  input  wire              rst_n,
  input  nca_pkg::tok_t    tok_i,
  output logic             adv,
  nca_out_if.source        out_ch
);

  logic                        out_valid_r;
  logic [nca_pkg::CLU_W-1:0]   cluster_r;
  logic [nca_pkg::DIST_W-1:0]  dist_r;
  logic [nca_pkg::COST_W-1:0]  out_cost_r;
  logic [nca_pkg::COST_W-1:0]  cost_r;

  logic [nca_pkg::DIST_W-1:0]  dist_nxt;
  logic [nca_pkg::COST_W:0]    cost_sum;
  logic [nca_pkg::COST_W-1:0]  cost_nxt;

  // Stall the row only when a result would land on a waiting one
  assign adv = !(out_valid_r && !out_ch.ready && tok_i.res);

  always_comb begin
    dist_nxt = tok_i.best_d[nca_pkg::DIST_W] ? '1 : tok_i.best_d[nca_pkg::DIST_W-1:0];
    cost_sum = {1'b0, cost_r} + (nca_pkg::COST_W + 1)'(dist_nxt);
    cost_nxt = cost_sum[nca_pkg::COST_W] ? '1 : cost_sum[nca_pkg::COST_W-1:0];
  end

  // Control: accumulator and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cost_r      <= '0;
    end else begin
      if (adv && tok_i.res) begin
        out_valid_r <= 1'b1;
        cost_r      <= cost_nxt;
      end else begin
        if (out_ch.ready) begin
          out_valid_r <= 1'b0;
        end
        if (adv && tok_i.clear) begin
          cost_r <= '0;
        end
      end
    end
  end

  // Payload of the waiting result
  always_ff @(posedge clk) begin
    if (adv && tok_i.res) begin
      cluster_r  <= tok_i.best_idx[nca_pkg::CLU_W-1:0];
      dist_r     <= dist_nxt;
      out_cost_r <= cost_nxt;
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.cluster         = cluster_r;
  assign out_ch.min_distance_sq = dist_r;
  assign out_ch.cost_total      = out_cost_r;

endmodule

`default_nettype wire

/* src/nearest_centroid_assign.sv */
// Nearest-centroid assignment for k-means.
// in_ch carries load, point and clear items; out_ch carries one result
// (cluster, min_distance_sq, cost_total) per point coordinate marked last.
// cfg_wr_en/cfg_wr_data write centroids_in_use (reset 16).
// Items move down a row of MAX_CENTROIDS cells, one cell per cycle unless stalled; each cell
// keeps one centroid's coordinates, accumulates its squared distance and
// takes one step of the minimum search as the last coordinate passes.
// Throughput: one item per cycle unless the row is stalled. A result passes the input register,
// the cell stages of the whole row and the output register before out_ch.valid.
// Reset: partial distances and cost clear at once; the coordinate store is
// then swept to zero one dimension per cycle, through all MAX_DIMS entries, with in_ch.ready
// low (configuration writes still land).
// Stall: while a result waits on out_ch the row keeps moving; it freezes,
// and in_ch.ready drops, only in a cycle where a second result reaches the
// end of the row before the first was taken.
`default_nettype none

module nearest_centroid_assign #(
  parameter int MAX_CENTROIDS = 16,
  parameter int MAX_DIMS      = 16
) (
  input  wire                        clk,
  input  wire                        rst_n,
  nca_in_if.sink                     in_ch,
  nca_out_if.source                  out_ch,
  input  wire                        cfg_wr_en,
  input  wire [nca_pkg::CFG_W-1:0]   cfg_wr_data
);

  localparam int DW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

  logic [nca_pkg::CFG_W-1:0] cfg_r;
  logic                      clr_busy_r;
  logic [DW-1:0]             clr_cnt_r;
  logic                      adv;
  nca_pkg::item_t            in_item_r;
  nca_pkg::item_t            item_nxt;
  logic [nca_pkg::CNT_W-1:0] n_act;

  nca_pkg::item_t item_w [MAX_CENTROIDS];
  nca_pkg::tok_t  tok_w  [MAX_CENTROIDS];

  // Configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= nca_pkg::CFG_RESET;
    end else if (cfg_wr_en) begin
      cfg_r <= cfg_wr_data;
    end
  end

  // Clamp the active count to 1..MAX_CENTROIDS
  always_comb begin
    priority if (cfg_r == '0) begin
      n_act = nca_pkg::CNT_W'(1);
    end else if (nca_pkg::CNT_W'(cfg_r) > nca_pkg::CNT_W'(MAX_CENTROIDS)) begin
      n_act = nca_pkg::CNT_W'(MAX_CENTROIDS);
    end else begin
      n_act = nca_pkg::CNT_W'(cfg_r);
    end
  end

  // Store clearing sweep after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      if (clr_cnt_r == DW'(MAX_DIMS - 1)) begin
        clr_busy_r <= 1'b0;
      end
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign in_ch.ready = adv && !clr_busy_r;

  // Input register: capture the transfer with its active count
  always_comb begin
    item_nxt.valid  = in_ch.valid && !clr_busy_r;
    item_nxt.op     = in_ch.opcode;
    item_nxt.cidx   = in_ch.centroid_index;
    item_nxt.didx   = in_ch.dim_index;
    item_nxt.dim_ok = nca_pkg::CNT_W'(in_ch.dim_index) < nca_pkg::CNT_W'(MAX_DIMS);
    item_nxt.value  = in_ch.value;
    item_nxt.last   = in_ch.last_coord;
    item_nxt.n_act  = n_act;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_item_r <= '0;
    end else if (adv) begin
      in_item_r <= item_nxt;
    end
  end

  // Row of centroid cells
  for (genvar i = 0; i < MAX_CENTROIDS; i++) begin : g_cell
    if (i == 0) begin : g_first
      nca_cell #(
        .CELL_IDX (i),
        .MAX_DIMS (MAX_DIMS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .clr_en   (clr_busy_r),
        .clr_addr (clr_cnt_r),
        .item_i   (in_item_r),
        .item_o   (item_w[i]),
        .tok_i    (nca_pkg::tok_t'('0)),
        .tok_o    (tok_w[i])
      );
    end else begin : g_next
      nca_cell #(
        .CELL_IDX (i),
        .MAX_DIMS (MAX_DIMS)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .clr_en   (clr_busy_r),
        .clr_addr (clr_cnt_r),
        .item_i   (item_w[i-1]),
        .item_o   (item_w[i]),
        .tok_i    (tok_w[i-1]),
        .tok_o    (tok_w[i])
      );
    end
  end

  // Cost and output register
  nca_cost u_cost (
    .clk    (clk),
    .rst_n  (rst_n),
    .tok_i  (tok_w[MAX_CENTROIDS-1]),
    .adv    (adv),
    .out_ch (out_ch)
  );

  // No result can be offered while the store is still being cleared
  a_no_out_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clr_busy_r |-> !out_ch.valid)
    else $error("result offered during store clear");

  // A stall freezes the whole row, including its far end
  a_row_frozen: assert property (@(posedge clk) disable iff (!rst_n)
    (!adv && $past(rst_n)) |=> ($stable(in_item_r) && $stable(item_w[MAX_CENTROIDS-1])))
    else $error("row moved during stall");

  // The running cost always includes the distance just reported
  a_cost_covers_dist: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.cost_total >= nca_pkg::COST_W'(out_ch.min_distance_sq)))
    else $error("cost total below reported distance");

endmodule

`default_nettype wire

/* dv/tb_nearest_centroid_assign.sv */
`timescale 1ns / 100ps

module tb_nearest_centroid_assign;

  localparam int NUM_CENT = 16;
  localparam int NUM_DIMS = 16;
  localparam logic [nca_pkg::OPC_W-1:0] OP_UNUSED = 2'd3;
  // row length plus output stage, then some margin
  localparam int PIPE_LAT = NUM_CENT + 3;
  localparam int SETTLE_CYCLES = PIPE_LAT + 6;
  localparam int MAX_GAP = 12;
  localparam int HOLD_CYCLES = 300;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RAND_PHASES = 8;
  localparam int PHASE_ITEMS = 155;
  localparam logic [nca_pkg::PART_W-1:0] PART_SAT = '1;
  localparam logic [nca_pkg::DIST_W-1:0] DIST_SAT = '1;
  localparam logic [nca_pkg::COST_W-1:0] COST_SAT = '1;

  // value mixes for coordinates
  localparam int VAL_FULL    = 0;
  localparam int VAL_NARROW  = 1;
  localparam int VAL_EXTREME = 2;

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [nca_pkg::CFG_W-1:0] cfg_wr_data;

  nca_in_if  in_ch();
  nca_out_if out_ch();

  nearest_centroid_assign i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // run limit
  int unsigned cycle_cnt = 0;
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Assignment predictor: centroid table, partial distances, cost and count
  // ---------------------------------------------------------------------------
  typedef struct packed {
    logic [nca_pkg::CLU_W-1:0]  cluster;
    logic [nca_pkg::DIST_W-1:0] min_dist;
    logic [nca_pkg::COST_W-1:0] cost;
  } assignment_t;

  assignment_t pending_assign_q[$];

  logic signed [nca_pkg::VAL_W-1:0] centroid_mem [NUM_CENT][NUM_DIMS];
  logic [nca_pkg::PART_W-1:0]       partial_sq [NUM_CENT];
  logic [nca_pkg::COST_W-1:0]       cost_sum;
  logic [nca_pkg::CFG_W-1:0]        centroid_count;

  int unsigned fail_cnt = 0;
  bit src_idle_en = 1'b1;
  bit sink_idle_en = 1'b1;
  bit hold_req = 1'b0;

  // count register clamped to 1..NUM_CENT
  function automatic int unsigned active_centroids();
    int unsigned n;
    n = centroid_count;
    if (n < 1) n = 1;
    if (n > NUM_CENT) n = NUM_CENT;
    return n;
  endfunction

  task automatic predict_assignment(input logic [nca_pkg::OPC_W-1:0] op,
                                    input logic [nca_pkg::CIDX_W-1:0] cidx,
                                    input logic [nca_pkg::DIM_W-1:0] didx,
                                    input logic signed [nca_pkg::VAL_W-1:0] val,
                                    input logic last);
    int unsigned n;
    int unsigned best;
    logic signed [nca_pkg::VAL_W:0] diff;
    logic [nca_pkg::VAL_W:0] mag;
    logic [63:0] acc;
    logic [nca_pkg::PART_W-1:0] best_sq;
    logic [nca_pkg::COST_W:0] cost_next;
    assignment_t res;
    n = active_centroids();
    case (op)
      nca_pkg::OP_LOAD: centroid_mem[cidx][didx] = val;
      nca_pkg::OP_CLEAR: cost_sum = '0;
      nca_pkg::OP_POINT: begin
        // accumulate squared difference for each active centroid, saturating
        for (int c = 0; c < n; c++) begin
          diff = {val[nca_pkg::VAL_W-1], val} -
                 {centroid_mem[c][didx][nca_pkg::VAL_W-1], centroid_mem[c][didx]};
          mag = diff[nca_pkg::VAL_W] ? -diff : diff;
          acc = 64'(partial_sq[c]) + 64'(mag) * 64'(mag);
          partial_sq[c] = (acc > 64'(PART_SAT)) ? PART_SAT : acc[nca_pkg::PART_W-1:0];
        end
        if (last) begin
          // strict less-than keeps the lowest index on ties
          best = 0;
          best_sq = partial_sq[0];
          for (int c = 1; c < n; c++) begin
            if (partial_sq[c] < best_sq) begin
              best_sq = partial_sq[c];
              best = c;
            end
          end
          res.cluster = best[nca_pkg::CLU_W-1:0];
          res.min_dist = (best_sq > nca_pkg::PART_W'(DIST_SAT)) ? DIST_SAT :
                                                                  best_sq[nca_pkg::DIST_W-1:0];
          cost_next = {1'b0, cost_sum} + (nca_pkg::COST_W+1)'(res.min_dist);
          cost_sum = cost_next[nca_pkg::COST_W] ? COST_SAT : cost_next[nca_pkg::COST_W-1:0];
          res.cost = cost_sum;
          foreach (partial_sq[c]) partial_sq[c] = '0;
          pending_assign_q = {pending_assign_q, res};
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  task automatic send_item(input logic [nca_pkg::OPC_W-1:0] op,
                           input logic [nca_pkg::CIDX_W-1:0] cidx,
                           input logic [nca_pkg::DIM_W-1:0] didx,
                           input logic signed [nca_pkg::VAL_W-1:0] val, input logic last);
    int unsigned gap;
    gap = src_idle_en ? $urandom_range(0, MAX_GAP) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.opcode         = op;
    in_ch.centroid_index = cidx;
    in_ch.dim_index      = didx;
    in_ch.value          = val;
    in_ch.last_coord     = last;
    in_ch.valid          = 1'b1;
    // wait for the transfer
    do @(posedge clk); while (!in_ch.ready);
    predict_assignment(op, cidx, didx, val, last);
  endtask

  task automatic load_coord(input logic [nca_pkg::CIDX_W-1:0] cidx,
                            input logic [nca_pkg::DIM_W-1:0] didx,
                            input logic signed [nca_pkg::VAL_W-1:0] val);
    send_item(nca_pkg::OP_LOAD, cidx, didx, val, logic'($urandom_range(0, 1)));
  endtask

  task automatic point_coord(input logic [nca_pkg::DIM_W-1:0] didx,
                             input logic signed [nca_pkg::VAL_W-1:0] val,
                             input logic last);
    send_item(nca_pkg::OP_POINT, nca_pkg::CIDX_W'($urandom), didx, val, last);
  endtask

  // idle input, wait for all results, then let the row empty
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (pending_assign_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_centroid_count(input logic [nca_pkg::CFG_W-1:0] k);
    drain();
    @(negedge clk);
    cfg_wr_en   = 1'b1;
    cfg_wr_data = k;
    @(negedge clk);
    cfg_wr_en   = 1'b0;
    centroid_count = k;
  endtask

  function automatic logic signed [nca_pkg::VAL_W-1:0] pick_value(input int style);
    int narrow_v;
    narrow_v = $urandom_range(0, 4);
    case (style)
      VAL_FULL: return nca_pkg::VAL_W'($urandom);
      VAL_NARROW: return nca_pkg::VAL_W'(narrow_v - 2);
      VAL_EXTREME: begin
        case ($urandom_range(0, 4))
          0: return 16'sh8000;
          1: return 16'sh7FFF;
          2: return 16'sh0000;
          3: return 16'shFFFF;
          default: return nca_pkg::VAL_W'($urandom);
        endcase
      end
      default: return nca_pkg::VAL_W'($urandom);
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Result side: receiver with random stalls and an optional long hold-off
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned sink_gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      sink_gap = sink_idle_en ? $urandom_range(0, MAX_GAP) : 0;
      if (hold_req) begin
        sink_gap += HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (sink_gap > 0) begin
        out_ch.ready = 1'b0;
        repeat (sink_gap) @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  // compare each result transfer with the oldest expected assignment
  always @(posedge clk) begin : result_check
    assignment_t exp_r;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_assign_q.size() == 0) begin
        $error("unexpected result: cluster %0d min_distance_sq %0d cost_total %0d",
               out_ch.cluster, out_ch.min_distance_sq, out_ch.cost_total);
        fail_cnt++;
      end else begin
        exp_r = pending_assign_q.pop_front();
        if (out_ch.cluster !== exp_r.cluster) begin
          $error("cluster: expected %0d, actual %0d", exp_r.cluster, out_ch.cluster);
          fail_cnt++;
        end
        if (out_ch.min_distance_sq !== exp_r.min_dist) begin
          $error("min_distance_sq: expected %0d, actual %0d", exp_r.min_dist,
                 out_ch.min_distance_sq);
          fail_cnt++;
        end
        if (out_ch.cost_total !== exp_r.cost) begin
          $error("cost_total: expected %0d, actual %0d", exp_r.cost, out_ch.cost_total);
          fail_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // last mark alone right after reset: zero table and partials, tie to index 0
  task automatic test_lone_last_mark();
    point_coord(4'd0, 16'sd0, 1'b1);
    point_coord(4'd15, 16'sh7FFF, 1'b1);
  endtask

  // extreme coordinates in the table and in points
  task automatic test_field_extremes();
    load_coord(4'd0, 4'd0, 16'sh7FFF);
    load_coord(4'd15, 4'd15, 16'sh8000);
    load_coord(4'd5, 4'd3, 16'shFFFF);
    load_coord(4'd10, 4'd0, 16'sh8000);
    point_coord(4'd0, 16'sh8000, 1'b0);
    point_coord(4'd15, 16'sh7FFF, 1'b1);
    point_coord(4'd3, 16'shFFFF, 1'b1);
    point_coord(4'd0, 16'sh7FFF, 1'b1);
  endtask

  // equal distances pick the lower index; repeated dim accumulates twice
  task automatic test_ties_and_repeats();
    load_coord(4'd3, 4'd1, 16'sd100);
    load_coord(4'd9, 4'd1, 16'sd100);
    point_coord(4'd1, 16'sd100, 1'b1);
    point_coord(4'd1, 16'sd50, 1'b0);
    point_coord(4'd1, 16'sd50, 1'b1);
  endtask

  // clear zeroes the cost, unused opcode does nothing
  task automatic test_clear_and_unused();
    send_item(nca_pkg::OP_CLEAR, nca_pkg::CIDX_W'($urandom), nca_pkg::DIM_W'($urandom),
              nca_pkg::VAL_W'($urandom), 1'b1);
    send_item(OP_UNUSED, nca_pkg::CIDX_W'($urandom), nca_pkg::DIM_W'($urandom),
              nca_pkg::VAL_W'($urandom), 1'b1);
    point_coord(4'd0, 16'sd1000, 1'b1);
  endtask

  // count register at and beyond its limits
  task automatic test_count_limits();
    logic [nca_pkg::CFG_W-1:0] k_list [6];
    k_list = '{5'd0, 5'd31, 5'd17, 5'd1, 5'd2, 5'd16};
    foreach (k_list[i]) begin
      write_centroid_count(k_list[i]);
      point_coord(4'd0, 16'sh8000, 1'b1);
    end
  endtask

  // partial distance saturation, which also saturates the reported distance
  task automatic test_partial_saturation();
    write_centroid_count(5'd1);
    load_coord(4'd0, 4'd7, 16'sh8000);
    repeat (34) point_coord(4'd7, 16'sh7FFF, 1'b0);
    point_coord(4'd7, 16'sh7FFF, 1'b1);
    write_centroid_count(5'd16);
    point_coord(4'd7, 16'sh7FFF, 1'b1);
  endtask

  // count changes between coordinates of one point
  task automatic test_count_mid_point();
    write_centroid_count(5'd16);
    point_coord(4'd2, 16'sd500, 1'b0);
    point_coord(4'd1, -16'sd700, 1'b0);
    write_centroid_count(5'd3);
    point_coord(4'd4, 16'sd9, 1'b0);
    write_centroid_count(5'd12);
    point_coord(4'd0, -16'sd20000, 1'b1);
  endtask

  // long receiver hold-off with back-to-back points to fill the row
  task automatic test_output_backpressure();
    drain();
    src_idle_en = 1'b0;
    hold_req = 1'b1;
    repeat (60) point_coord(nca_pkg::DIM_W'($urandom), nca_pkg::VAL_W'($urandom), 1'b1);
    src_idle_en = 1'b1;
  endtask

  // mixed loads, points and noise under one count setting
  task automatic random_phase(input logic [nca_pkg::CFG_W-1:0] k, input int style,
                              input int n_items);
    int sent;
    int pick;
    int n_coord;
    int unsigned n_act;
    bit seq_dims;
    logic [nca_pkg::CIDX_W-1:0] cidx;
    logic [nca_pkg::DIM_W-1:0] didx;
    write_centroid_count(k);
    n_act = active_centroids();
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
        // rewrite a few coordinates, mostly of active centroids
        n_coord = $urandom_range(1, 8);
        for (int i = 0; i < n_coord; i++) begin
          cidx = ($urandom_range(0, 3) == 0) ? nca_pkg::CIDX_W'($urandom) :
                 nca_pkg::CIDX_W'($urandom_range(0, n_act - 1));
          load_coord(cidx, nca_pkg::DIM_W'($urandom), pick_value(style));
        end
        sent += n_coord;
      end else if (pick < 18) begin
        // noise: any opcode with random fields
        send_item(nca_pkg::OPC_W'($urandom), nca_pkg::CIDX_W'($urandom),
                  nca_pkg::DIM_W'($urandom), pick_value(style),
                  logic'($urandom_range(0, 1)));
        sent++;
      end else begin
        // one point: mostly a few dims, now and then all of them
        n_coord = ($urandom_range(0, 9) == 0) ? NUM_DIMS : $urandom_range(1, 5);
        seq_dims = ($urandom_range(0, 2) != 0);
        for (int i = 0; i < n_coord; i++) begin
          didx = seq_dims ? nca_pkg::DIM_W'(i) : nca_pkg::DIM_W'($urandom);
          point_coord(didx, pick_value(style), logic'(i == n_coord - 1));
        end
        sent += n_coord;
      end
    end
  endtask

  task automatic test_random_traffic();
    logic [nca_pkg::CFG_W-1:0] k_list [RAND_PHASES];
    k_list = '{5'd16, 5'd1, 5'd0, 5'd31, 5'd2, 5'd8, 5'd17, nca_pkg::CFG_W'($urandom)};
    for (int p = 0; p < RAND_PHASES; p++) begin
      // first phase runs with no idling on either side
      src_idle_en  = (p != 0) && ($urandom_range(0, 3) != 0);
      sink_idle_en = (p != 0) && ($urandom_range(0, 3) != 0);
      random_phase(k_list[p], p % 3, PHASE_ITEMS);
    end
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n                = 1'b0;
    cfg_wr_en            = 1'b0;
    cfg_wr_data          = nca_pkg::CFG_RESET;
    in_ch.valid          = 1'b0;
    in_ch.opcode         = nca_pkg::OP_LOAD;
    in_ch.centroid_index = '0;
    in_ch.dim_index      = '0;
    in_ch.value          = '0;
    in_ch.last_coord     = 1'b0;

    // predictor reset state
    foreach (centroid_mem[c, d]) centroid_mem[c][d] = '0;
    foreach (partial_sq[c]) partial_sq[c] = '0;
    cost_sum = '0;
    centroid_count = nca_pkg::CFG_RESET;

    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    test_lone_last_mark();
    test_field_extremes();
    test_ties_and_repeats();
    test_clear_and_unused();
    test_count_limits();
    test_partial_saturation();
    test_count_mid_point();
    test_output_backpressure();
    test_random_traffic();

    drain();
    repeat (PIPE_LAT) @(posedge clk);
    if (fail_cnt == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
